### hw/rtl/kda_pkg.sv
package kda_pkg;

    // Key array and counter sizing
    localparam int NUM_KEYS         = 4;
    localparam int DEBOUNCE_SAMPLES = 4;
    localparam int COUNT_WIDTH      = 16;
    localparam int KEY_SEL_W        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Fixed field widths of the channels and the configuration port
    localparam int KEY_INDEX_W = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MASK_W      = 4;

    // Reset values of the configuration registers
    localparam logic [COUNT_WIDTH-1:0] FIRST_DELAY_RESET     = COUNT_WIDTH'(100);
    localparam logic [COUNT_WIDTH-1:0] REPEAT_INTERVAL_RESET = COUNT_WIDTH'(10);
    localparam logic [MASK_W-1:0]      REPEAT_MASK_RESET     = MASK_W'(7);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef logic [COUNT_WIDTH-1:0]      count_t;
    typedef logic [DEBOUNCE_SAMPLES-1:0] history_t;
    typedef logic [NUM_KEYS-1:0]         key_vec_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_DELAY     = 2'd0,
        REG_REPEAT_INTERVAL = 2'd1,
        REG_REPEAT_MASK     = 2'd2
    } cfg_reg_t;

    // Event kind codes
    typedef enum logic {
        EVT_PRESS  = 1'b0,
        EVT_REPEAT = 1'b1
    } event_kind_t;

    // Per-key result of one tick
    typedef struct packed {
        logic        fire;
        event_kind_t kind;
    } lane_evt_t;

    // Settings shared by all key lanes
    typedef struct packed {
        count_t first_delay;
        count_t interval;
    } lane_cfg_t;

endpackage

### hw/rtl/kda_in_if.sv
interface kda_in_if;
    import kda_pkg::*;

    logic     valid;
    logic     ready;
    key_vec_t key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

### hw/rtl/kda_out_if.sv
interface kda_out_if;
    import kda_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KEY_INDEX_W-1:0] key_index;
    logic                   event_kind;
    logic                   last_of_tick;

    modport source (output valid, output key_index, output event_kind, output last_of_tick,
                    input ready);
    modport sink   (input valid, input key_index, input event_kind, input last_of_tick,
                    output ready);
endinterface

### hw/rtl/key_debounce_auto_repeat.sv
// Key debouncer with auto-repeat for four active-low keys.
//
// key_in carries one sampling tick per transaction: key_levels bit i is the
// raw level of key i (1 released, 0 pressed). event_out carries one event per
// transaction: key_index, event_kind (0 press, 1 auto-repeat) and last_of_tick
// on the final event of a tick. A tick with no events produces nothing.
//
// All keys are processed in parallel on the accepting edge; their events are
// merged in key order and leave one per cycle while the receiver is ready.
// The first event of a tick passes through the pending register and then the
// output register. The next tick is taken in the cycle the last event of the
// current one moves into the output register.
//
// Configuration (cfg_wr_en, cfg_index, cfg_data) is to be written while idle;
// the block does not enforce this. Index 0 first delay, 1 repeat interval,
// 2 repeat enable mask; other indexes are ignored. Reset loads 100, 10 and 7
// and marks all keys released. When the receiver stalls, the output register
// and the pending events hold, and key_in.ready stays low while any remain.
module key_debounce_auto_repeat (
    input  logic                              clk,
    input  logic                              rst_n,
    kda_in_if.sink                            key_in,
    kda_out_if.source                         event_out,
    input  logic                              cfg_wr_en,
    input  logic [kda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kda_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kda_pkg::*;

    count_t             first_delay_reg;
    count_t             interval_reg;
    logic [MASK_W-1:0]  mask_reg;

    lane_cfg_t                    lane_cfg;
    lane_evt_t [NUM_KEYS-1:0]     lane_evt;
    logic                         take_ready;
    logic                         tick;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg <= FIRST_DELAY_RESET;
            interval_reg    <= REPEAT_INTERVAL_RESET;
            mask_reg        <= REPEAT_MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FIRST_DELAY:     first_delay_reg <= COUNT_WIDTH'(cfg_data);
                REG_REPEAT_INTERVAL: interval_reg    <= COUNT_WIDTH'(cfg_data);
                REG_REPEAT_MASK:     mask_reg        <= cfg_data[MASK_W-1:0];
                default:             ;
            endcase
        end
    end

    assign lane_cfg.first_delay = first_delay_reg;
    assign lane_cfg.interval    = interval_reg;

    // Take a tick whenever the merger can hold its events
    assign key_in.ready = take_ready;
    assign tick         = key_in.valid && take_ready;

    // One lane per key
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kda_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .tick    (tick),
            .level   (key_in.key_levels[k]),
            .enabled ((k < MASK_W) ? mask_reg[k % MASK_W] : 1'b0),
            .cfg     (lane_cfg),
            .evt     (lane_evt[k])
        );
    end

    // Serialize lane events in key order
    kda_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (tick),
        .lane_evt   (lane_evt),
        .take_ready (take_ready),
        .event_out  (event_out)
    );

endmodule

### hw/rtl/kda_lane.sv
module kda_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  logic                level,
    input  logic                enabled,
    input  kda_pkg::lane_cfg_t  cfg,
    output kda_pkg::lane_evt_t  evt
);
    import kda_pkg::*;

    history_t hist_reg, hist_next;
    logic     deb_reg, deb_next;
    count_t   hold_reg, hold_next;
    count_t   thr_reg, thr_next;

    logic [COUNT_WIDTH:0] hold_inc;
    logic [COUNT_WIDTH:0] thr_sum;
    logic                 press;
    logic                 repeat_hit;

    // Debounce, hold timing and repeat scheduling for one key
    always_comb
    begin
        hist_next = {hist_reg[DEBOUNCE_SAMPLES-2:0], level};
        deb_next  = deb_reg;
        hold_next = hold_reg;
        thr_next  = thr_reg;
        hold_inc  = {1'b0, hold_reg} + (COUNT_WIDTH+1)'(1);

        if (hist_next == '0)
        begin
            deb_next = 1'b0;
            if (enabled)
                hold_next = hold_inc[COUNT_WIDTH] ? COUNT_MAX : hold_inc[COUNT_WIDTH-1:0];
        end
        else if (hist_next == '1)
        begin
            deb_next = 1'b1;
            if (enabled)
                hold_next = '0;
        end

        // Press on a released-to-pressed change of the debounced level
        press = deb_reg && !deb_next;

        // Advance the threshold on a repeat, rearm it while not held
        thr_sum    = {1'b0, thr_reg} + {1'b0, cfg.interval};
        repeat_hit = 1'b0;
        if (hold_next != '0)
        begin
            if (hold_next >= thr_reg)
            begin
                repeat_hit = 1'b1;
                thr_next   = thr_sum[COUNT_WIDTH] ? COUNT_MAX : thr_sum[COUNT_WIDTH-1:0];
            end
        end
        else
        begin
            thr_next = cfg.first_delay;
        end

        evt.fire = press || repeat_hit;
        evt.kind = press ? EVT_PRESS : EVT_REPEAT;
    end

    // Commit key state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '1;
            deb_reg  <= 1'b1;
            hold_reg <= '0;
            thr_reg  <= FIRST_DELAY_RESET;
        end
        else if (tick)
        begin
            hist_reg <= hist_next;
            deb_reg  <= deb_next;
            hold_reg <= hold_next;
            thr_reg  <= thr_next;
        end
    end

endmodule

### hw/rtl/kda_merge.sv
module kda_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  kda_pkg::lane_evt_t [kda_pkg::NUM_KEYS-1:0] lane_evt,
    output logic                                 take_ready,
    kda_out_if.source                            event_out
);
    import kda_pkg::*;

    key_vec_t pend_fire_reg, pend_fire_next;
    key_vec_t pend_kind_reg, pend_kind_next;

    logic                   out_valid_reg, out_valid_next;
    logic [KEY_INDEX_W-1:0] out_key_reg, out_key_next;
    logic                   out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;

    logic [KEY_SEL_W-1:0] sel;
    key_vec_t             rest;
    key_vec_t             fire_after;
    logic                 slot_free;
    logic                 pop;

    // Pick the lowest pending key and drain one event per cycle while the output slot is free
    always_comb
    begin
        sel = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (pend_fire_reg[k])
                sel = KEY_SEL_W'(k);
        end

        rest      = pend_fire_reg;
        rest[sel] = 1'b0;

        slot_free  = !out_valid_reg || event_out.ready;
        pop        = slot_free && (pend_fire_reg != '0);
        fire_after = pop ? rest : pend_fire_reg;
        take_ready = (fire_after == '0);

        pend_fire_next = fire_after;
        pend_kind_next = pend_kind_reg;
        if (load)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                pend_fire_next[k] = lane_evt[k].fire;
                pend_kind_next[k] = lane_evt[k].kind;
            end
        end

        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_key_next   = KEY_INDEX_W'(sel);
            out_kind_next  = pend_kind_reg[sel];
            out_last_next  = (rest == '0);
        end
        else if (event_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_fire_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_fire_reg <= pend_fire_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        out_key_reg   <= out_key_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    assign event_out.valid        = out_valid_reg;
    assign event_out.key_index    = out_key_reg;
    assign event_out.event_kind   = out_kind_reg;
    assign event_out.last_of_tick = out_last_reg;

endmodule
